@@ hw/rtl/cgu_pkg.sv @@
`timescale 1ns / 1ps

package cgu_pkg;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_POINT = 2'd1,
      OP_END   = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   localparam logic [2:0] REG_CPM    = 3'd0;
   localparam logic [2:0] REG_SMIN   = 3'd1;
   localparam logic [2:0] REG_SMAX   = 3'd2;
   localparam logic [2:0] REG_RADIUS = 3'd3;
   localparam logic [2:0] REG_WINDOW = 3'd4;

   localparam logic [7:0] COST_FULL    = 8'd100;
   localparam logic [7:0] CELL_UNKNOWN = 8'hFF;

   localparam int WIN_W = 14;
   localparam logic signed [WIN_W-1:0] WIN_MIN = -14'sd8192;
   localparam logic signed [WIN_W-1:0] WIN_MAX = 14'sd8191;

   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

@@ hw/rtl/cgu_ram.sv @@
`timescale 1ns / 1ps

module cgu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cost_grid_update_unit.sv @@
`timescale 1ns / 1ps

// Cost grid of GRID_CELLS x GRID_CELLS cells in one RAM, driven by a sequencer around one
// shared 25x18 multiplier and a one-bit-per-cycle divider. After reset the block sweeps the
// RAM to unknown, one cell per cycle, before it takes the first request (register writes are
// taken throughout). Requests: begin frame; read; point, which is ignored, given a fixed cost
// or given an interpolated cost (7 divider steps); end frame, which clears the clear box
// clipped to window and grid. One request is in work at a time; the response register frees
// the sequencer as soon as the result is loaded.
module cost_grid_update_unit #(
   parameter int GRID_CELLS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [15:0] req_distance,
   input  logic [11:0]        req_col,
   input  logic [11:0]        req_row,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [7:0]  rsp_cell_value,
   output logic [1:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int LOG_W  = $clog2(GRID_CELLS);
   localparam int DEPTH  = GRID_CELLS * GRID_CELLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SQ_W   = 2 * LOG_W;
   localparam int CELL_W = cgu_pkg::MUL_P_W - 16 + 1;
   localparam logic signed [15:0] CTR   = 16'(GRID_CELLS / 2);
   localparam logic signed [15:0] G_TOP = 16'(GRID_CELLS - 1);

   typedef enum logic [4:0] {
      S_SWEEP, S_IDLE, S_MX, S_MY, S_CELL, S_CHK, S_DINIT, S_DIV, S_WR,
      S_RD, S_RDW, S_CBND, S_CR2, S_CROW, S_CDY, S_CDX, S_CCHK, S_DONE
   } state_type;

   state_type state_ff;

   logic [15:0] cpm_ff, smin_ff, smax_ff;
   logic [11:0] radius_ff;
   logic [12:0] window_ff;
   logic signed [cgu_pkg::WIN_W-1:0] win_col_ff, win_row_ff;

   logic [1:0]         op_ff;
   logic signed [23:0] px_ff, py_ff;
   logic signed [15:0] dist_ff;
   logic [11:0]        col_ff, row_ff;

   logic signed [cgu_pkg::MUL_A_W-1:0] mul_a;
   logic signed [cgu_pkg::MUL_B_W-1:0] mul_b;
   logic signed [cgu_pkg::MUL_P_W-1:0] prod_ff;

   logic signed [CELL_W-1:0] cx_ff, cy_ff;
   logic [7:0]  cost_ff;
   logic [22:0] rem_ff;
   logic [21:0] dsh_ff;
   logic [6:0]  quo_ff;
   logic [2:0]  step_ff;

   logic [LOG_W-1:0] r0_ff, r1_ff, c0_ff, c1_ff, x_ff, y_ff;
   logic             empty_ff;
   logic [23:0]      rr_ff;
   logic [SQ_W-1:0]  dy2_ff;

   logic [ADDR_W-1:0] sweep_ff;
   logic [7:0]        res_value_ff;
   logic [1:0]        res_status_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_value_ff;
   logic [1:0]        rsp_status_ff;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata, mem_rdata;

   logic signed [CELL_W-1:0]  cell_now;
   logic signed [CELL_W:0]    org_x, org_y;
   logic signed [cgu_pkg::WIN_W-1:0] org_x_sat, org_y_sat;
   logic signed [CELL_W:0]    rel_x, rel_y, wside;
   logic                      in_x, in_y;
   logic signed [15:0]        rad_s, wr_s, wc_s, w_s;
   logic signed [15:0]        b_r0, b_r1, b_c0, b_c1;
   logic signed [LOG_W:0]     dx, dy;
   logic [SQ_W:0]             dist2;
   logic                      wr_cfg;

   function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic signed [15:0] c);
      logic signed [15:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic signed [15:0] c);
      logic signed [15:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [cgu_pkg::WIN_W-1:0] sat_win(
         input logic signed [CELL_W:0] v);
      if (v < (CELL_W+1)'(cgu_pkg::WIN_MIN)) begin
         return cgu_pkg::WIN_MIN;
      end else if (v > (CELL_W+1)'(cgu_pkg::WIN_MAX)) begin
         return cgu_pkg::WIN_MAX;
      end
      return cgu_pkg::WIN_W'(v);
   endfunction

   // configuration
   assign wr_cfg     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[4:2])
         cgu_pkg::REG_CPM:    csr_prdata = {16'd0, cpm_ff};
         cgu_pkg::REG_SMIN:   csr_prdata = {16'd0, smin_ff};
         cgu_pkg::REG_SMAX:   csr_prdata = {16'd0, smax_ff};
         cgu_pkg::REG_RADIUS: csr_prdata = {20'd0, radius_ff};
         cgu_pkg::REG_WINDOW: csr_prdata = {19'd0, window_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // datapath helpers
   assign cell_now  = CELL_W'($signed(prod_ff[cgu_pkg::MUL_P_W-1:16]))
                      + CELL_W'(GRID_CELLS / 2);
   assign wside     = (CELL_W+1)'({1'b0, window_ff});
   assign org_x     = (CELL_W+1)'(cx_ff) - (CELL_W+1)'({1'b0, window_ff[12:1]});
   assign org_y     = (CELL_W+1)'(cell_now) - (CELL_W+1)'({1'b0, window_ff[12:1]});
   assign org_x_sat = sat_win(org_x);
   assign org_y_sat = sat_win(org_y);
   assign rel_x     = (CELL_W+1)'(cx_ff) - (CELL_W+1)'(win_col_ff);
   assign rel_y     = (CELL_W+1)'(cy_ff) - (CELL_W+1)'(win_row_ff);
   assign in_x      = (rel_x >= 0) && (rel_x < wside) && (cx_ff >= 0)
                      && (cx_ff < CELL_W'(GRID_CELLS));
   assign in_y      = (rel_y >= 0) && (rel_y < wside) && (cy_ff >= 0)
                      && (cy_ff < CELL_W'(GRID_CELLS));

   assign rad_s = 16'({4'd0, radius_ff});
   assign wr_s  = 16'(win_row_ff);
   assign wc_s  = 16'(win_col_ff);
   assign w_s   = 16'({3'd0, window_ff});
   assign b_r0  = max3(CTR - rad_s, wr_s, 16'sd0);
   assign b_r1  = min3(CTR + rad_s, wr_s + w_s - 16'sd1, G_TOP);
   assign b_c0  = max3(CTR - rad_s, wc_s, 16'sd0);
   assign b_c1  = min3(CTR + rad_s, wc_s + w_s - 16'sd1, G_TOP);

   assign dx    = $signed({1'b0, x_ff}) - (LOG_W+1)'(GRID_CELLS / 2);
   assign dy    = $signed({1'b0, y_ff}) - (LOG_W+1)'(GRID_CELLS / 2);
   assign dist2 = (SQ_W+1)'(dy2_ff) + (SQ_W+1)'(prod_ff[SQ_W-1:0]);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MX: begin
            mul_a = cgu_pkg::MUL_A_W'(px_ff);
            mul_b = $signed({2'b00, cpm_ff});
         end
         S_MY: begin
            mul_a = cgu_pkg::MUL_A_W'(py_ff);
            mul_b = $signed({2'b00, cpm_ff});
         end
         S_CHK: begin
            mul_a = cgu_pkg::MUL_A_W'($signed({1'b0, smax_ff}) - 17'(dist_ff));
            mul_b = cgu_pkg::MUL_B_W'($signed({1'b0, cgu_pkg::COST_FULL}));
         end
         S_CBND: begin
            mul_a = $signed({13'd0, radius_ff});
            mul_b = $signed({6'd0, radius_ff});
         end
         S_CROW: begin
            mul_a = cgu_pkg::MUL_A_W'(dy);
            mul_b = cgu_pkg::MUL_B_W'(dy);
         end
         S_CDX: begin
            mul_a = cgu_pkg::MUL_A_W'(dx);
            mul_b = cgu_pkg::MUL_B_W'(dx);
         end
         default: begin
         end
      endcase
   end

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = cost_ff;
      case (state_ff)
         S_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = cgu_pkg::CELL_UNKNOWN;
         end
         S_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(cy_ff) * ADDR_W'(GRID_CELLS) + ADDR_W'(cx_ff);
         end
         S_CCHK: begin
            mem_we    = (32'(dist2) <= 32'(rr_ff));
            mem_waddr = ADDR_W'(y_ff) * ADDR_W'(GRID_CELLS) + ADDR_W'(x_ff);
            mem_wdata = 8'd0;
         end
         default: begin
         end
      endcase
   end

   assign mem_re    = (state_ff == S_RD);
   assign mem_raddr = ADDR_W'(row_ff) * ADDR_W'(GRID_CELLS) + ADDR_W'(col_ff);

   cgu_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_ff      <= '0;
         cpm_ff        <= 16'd256;
         smin_ff       <= 16'd1280;
         smax_ff       <= 16'd2560;
         radius_ff     <= 12'd10;
         window_ff     <= 13'd200;
         win_col_ff    <= '0;
         win_row_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (wr_cfg) begin
            unique case (csr_paddr[4:2])
               cgu_pkg::REG_CPM:    cpm_ff    <= csr_pwdata[15:0];
               cgu_pkg::REG_SMIN:   smin_ff   <= csr_pwdata[15:0];
               cgu_pkg::REG_SMAX:   smax_ff   <= csr_pwdata[15:0];
               cgu_pkg::REG_RADIUS: radius_ff <= csr_pwdata[11:0];
               cgu_pkg::REG_WINDOW: window_ff <= csr_pwdata[12:0];
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  op_ff         <= req_operation;
                  px_ff         <= req_pos_x;
                  py_ff         <= req_pos_y;
                  dist_ff       <= req_distance;
                  col_ff        <= req_col;
                  row_ff        <= req_row;
                  res_value_ff  <= 8'd0;
                  res_status_ff <= cgu_pkg::ST_DONE;
                  unique case (cgu_pkg::op_type'(req_operation))
                     cgu_pkg::OP_BEGIN, cgu_pkg::OP_POINT: state_ff <= S_MX;
                     cgu_pkg::OP_END: state_ff <= S_CBND;
                     cgu_pkg::OP_READ: begin
                        if (req_col < 12'(GRID_CELLS) && req_row < 12'(GRID_CELLS)
                            || GRID_CELLS == 4096) begin
                           state_ff <= S_RD;
                        end else begin
                           res_status_ff <= cgu_pkg::ST_RANGE;
                           state_ff      <= S_DONE;
                        end
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_MX: state_ff <= S_MY;
            S_MY: begin
               cx_ff    <= cell_now;
               state_ff <= S_CELL;
            end
            S_CELL: begin
               cy_ff <= cell_now;
               if (op_ff == cgu_pkg::OP_BEGIN) begin
                  win_col_ff <= org_x_sat;
                  win_row_ff <= org_y_sat;
                  state_ff   <= S_DONE;
               end else begin
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (!(in_x && in_y)) begin
                  res_status_ff <= cgu_pkg::ST_IGNORED;
                  state_ff      <= S_DONE;
               end else if (dist_ff < 0 || dist_ff[14:0] <= smin_ff[14:0] && smin_ff[15] == 1'b0
                            || smin_ff[15]) begin
                  if (dist_ff < 0 || {1'b0, dist_ff[14:0]} <= smin_ff) begin
                     cost_ff  <= cgu_pkg::COST_FULL;
                     state_ff <= S_WR;
                  end else if ({1'b0, dist_ff[14:0]} <= smax_ff) begin
                     state_ff <= S_DINIT;
                  end else begin
                     cost_ff  <= 8'd0;
                     state_ff <= S_WR;
                  end
               end else if ({1'b0, dist_ff[14:0]} <= smax_ff) begin
                  state_ff <= S_DINIT;
               end else begin
                  cost_ff  <= 8'd0;
                  state_ff <= S_WR;
               end
            end
            S_DINIT: begin
               rem_ff   <= prod_ff[22:0];
               dsh_ff   <= {smax_ff - smin_ff, 6'd0};
               quo_ff   <= '0;
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if ({1'b0, rem_ff} >= {2'b00, dsh_ff}) begin
                  rem_ff <= rem_ff - {1'b0, dsh_ff};
                  quo_ff <= {quo_ff[5:0], 1'b1};
               end else begin
                  quo_ff <= {quo_ff[5:0], 1'b0};
               end
               dsh_ff  <= dsh_ff >> 1;
               step_ff <= step_ff + 1'b1;
               if (step_ff == 3'd6) begin
                  state_ff <= S_WR;
               end
            end
            S_WR: begin
               res_value_ff <= cost_ff;
               state_ff     <= S_DONE;
            end
            S_RD: state_ff <= S_RDW;
            S_RDW: begin
               res_value_ff <= mem_rdata;
               state_ff     <= S_DONE;
            end
            S_CBND: begin
               r0_ff    <= LOG_W'(b_r0);
               r1_ff    <= LOG_W'(b_r1);
               c0_ff    <= LOG_W'(b_c0);
               c1_ff    <= LOG_W'(b_c1);
               empty_ff <= (b_r0 > b_r1) || (b_c0 > b_c1);
               state_ff <= S_CR2;
            end
            S_CR2: begin
               rr_ff <= prod_ff[23:0];
               y_ff  <= r0_ff;
               if (empty_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_CROW;
               end
            end
            S_CROW: begin
               x_ff     <= c0_ff;
               state_ff <= S_CDY;
            end
            S_CDY: begin
               dy2_ff   <= prod_ff[SQ_W-1:0];
               state_ff <= S_CDX;
            end
            S_CDX: state_ff <= S_CCHK;
            S_CCHK: begin
               if (x_ff == c1_ff) begin
                  if (y_ff == r1_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     y_ff     <= y_ff + 1'b1;
                     state_ff <= S_CROW;
                  end
               end else begin
                  x_ff     <= x_ff + 1'b1;
                  state_ff <= S_CDX;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= res_value_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_DIV && step_ff == 3'd6) begin
            cost_ff <= {quo_ff[5:0], ({1'b0, rem_ff} >= {2'b00, dsh_ff})} == 7'd0
                       ? 8'd0 : {1'b0, quo_ff[5:0], ({1'b0, rem_ff} >= {2'b00, dsh_ff})};
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = $signed(rsp_value_ff);
   assign rsp_status     = rsp_status_ff;

endmodule

@@ hw/rtl/cgu_checker.sv @@
`timescale 1ns / 1ps

module cgu_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [7:0] rsp_cell_value,
   input logic [1:0]        rsp_status
);

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == cgu_pkg::ST_DONE || rsp_status == cgu_pkg::ST_IGNORED
                     || rsp_status == cgu_pkg::ST_RANGE))
      else $error("invalid response status");

   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != cgu_pkg::ST_DONE) |-> (rsp_cell_value == 8'sd0))
      else $error("flagged response carries a value");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cell_value >= -8'sd1 && rsp_cell_value <= 8'sd100))
      else $error("cell value out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value) && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

endmodule

bind cost_grid_update_unit cgu_checker u_cgu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cell_value (rsp_cell_value),
   .rsp_status     (rsp_status)
);
